@@ src/mbet_pkg.sv @@
// Shared types and constants of the Mandelbrot escape-time block.
`timescale 1ns / 1ps

package mbet_pkg;

  localparam int PIXEL_WIDTH     = 12;
  localparam int COUNT_WIDTH     = 16;
  localparam int N_WIDTH         = 20;
  localparam int SPAN_WIDTH      = 13;
  localparam int OFFSET_WIDTH    = 17;
  localparam int STEP_WIDTH      = 32;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 32;

  // Multiplier digit taken per cycle.
  localparam int MUL_DIGIT = 16;

  // floor(v / 10) = (v * RECIP_10) >> RECIP_SHIFT for any 32-bit v.
  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // Escape when |z|^2 exceeds this value.
  localparam int ESCAPE_LIMIT = 4;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_POSITION_OFFSET = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PIXEL_STEP      = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ITERATION_CAP   = 3'd4;

  localparam logic [SPAN_WIDTH-1:0]          RESET_IMAGE_WIDTH     = 13'd500;
  localparam logic [SPAN_WIDTH-1:0]          RESET_IMAGE_HEIGHT    = 13'd500;
  localparam logic signed [OFFSET_WIDTH-1:0] RESET_POSITION_OFFSET = 17'sd0;
  localparam logic [STEP_WIDTH-1:0]          RESET_PIXEL_STEP      = 32'd2147484;
  localparam logic [COUNT_WIDTH-1:0]         RESET_ITERATION_CAP   = 16'd100;

  typedef struct packed {
    logic [PIXEL_WIDTH-1:0] pixel_column;
    logic [PIXEL_WIDTH-1:0] pixel_row;
  } pixel_t;

  typedef struct packed {
    logic                   escaped;
    logic [COUNT_WIDTH-1:0] iteration_count;
    logic [COUNT_WIDTH-1:0] blue_level;
  } result_t;

endpackage

@@ src/mandelbrot_escape_time.sv @@
// Top level of the Mandelbrot escape-time evaluator.
// Takes one pixel (column, row), maps it to c in signed Q4.FRAC_BITS, iterates
// z = z^2 + c until |z|^2 > 4 or iteration_cap is reached and returns the
// escaped flag, the count and a blue level. One pixel is worked on at a time;
// pixel_stall stays high until its result is in the output register. The
// products of the mapping, the iteration and the blue level all go through one
// shared multiplier, which works through K = ceil(max(FRAC_BITS + 4, 32) / 16)
// digits of its second operand. A pixel takes two products for the mapping,
// three products and a check per iteration, and, when it escapes, the check
// and two squares that detect it, and one product for the blue level. A
// finished result waits in the output register while the next pixel is taken.
// Registers are written through the cfg port, which is ready whenever rst is
// low; write them only while the block is idle.
`timescale 1ns / 1ps

module mandelbrot_escape_time #(
  parameter int FRAC_BITS   = 28,
  parameter int COORD_WIDTH = 12
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     pixel_valid,
  output logic                                     pixel_stall,
  input  mbet_pkg::pixel_t                         pixel,
  output logic                                     result_valid,
  input  logic                                     result_stall,
  output mbet_pkg::result_t                        result,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [mbet_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [mbet_pkg::CFG_DATA_WIDTH-1:0]      cfg_data
);

  localparam int QW     = FRAC_BITS + 4;
  localparam int EW     = FRAC_BITS + 10;
  localparam int MW     = (QW > 32) ? QW : 32;
  localparam int DIG    = mbet_pkg::MUL_DIGIT;
  localparam int MUL_PW = MW + ((MW + DIG - 1) / DIG) * DIG;
  localparam int NW     = mbet_pkg::N_WIDTH;
  localparam int PW     = mbet_pkg::PIXEL_WIDTH;
  localparam int CNTW   = mbet_pkg::COUNT_WIDTH;
  localparam int CU     = (COORD_WIDTH < PW) ? COORD_WIDTH : PW;

  localparam logic [PW-1:0]         COORD_MASK = PW'((64'd1 << CU) - 64'd1);
  localparam logic [MUL_PW-1:0]     SAT_MAG    = MUL_PW'(1) << (FRAC_BITS + 3);
  localparam logic signed [EW-1:0]  SAT_HI     = (EW'(1) <<< (FRAC_BITS + 3)) - EW'(1);
  localparam logic signed [EW-1:0]  SAT_LO     = -(EW'(1) <<< (FRAC_BITS + 3));
  localparam logic signed [EW-1:0]  ESC_LIMIT  = EW'(mbet_pkg::ESCAPE_LIMIT) <<< FRAC_BITS;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MAP_RE = 4'd1;
  localparam logic [3:0] S_MAP_IM = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_SQX    = 4'd4;
  localparam logic [3:0] S_SQY    = 4'd5;
  localparam logic [3:0] S_XY     = 4'd6;
  localparam logic [3:0] S_BLUE   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  function automatic logic [QW-1:0] abs_q(input logic signed [QW-1:0] v);
    return v[QW-1] ? QW'(-v) : QW'(v);
  endfunction

  function automatic logic [NW-1:0] abs_n(input logic signed [NW-1:0] v);
    return v[NW-1] ? NW'(-v) : NW'(v);
  endfunction

  // Signed value from a magnitude and a sign, clamped to [-8, 8).
  function automatic logic signed [QW-1:0] sat_mag(input logic [MUL_PW-1:0] mag,
                                                  input logic neg);
    if (mag >= SAT_MAG) begin
      return neg ? QW'(SAT_MAG) : QW'(SAT_MAG - MUL_PW'(1));
    end
    return neg ? -QW'(mag) : QW'(mag);
  endfunction

  function automatic logic signed [QW-1:0] sat_ext(input logic signed [EW-1:0] v);
    if (v > SAT_HI) begin
      return QW'(SAT_HI);
    end else if (v < SAT_LO) begin
      return QW'(SAT_LO);
    end
    return QW'(v);
  endfunction

  // Configuration registers
  logic [mbet_pkg::SPAN_WIDTH-1:0]          image_width;
  logic [mbet_pkg::SPAN_WIDTH-1:0]          image_height;
  logic signed [mbet_pkg::OFFSET_WIDTH-1:0] position_offset;
  logic [mbet_pkg::STEP_WIDTH-1:0]          pixel_step;
  logic [CNTW-1:0]                          iteration_cap;

  // Sequencer and datapath registers
  logic [3:0]              state;
  logic                    issued;
  logic [CNTW-1:0]         count;
  logic signed [NW-1:0]    n_re;
  logic signed [NW-1:0]    n_im;
  logic signed [QW-1:0]    c_re;
  logic signed [QW-1:0]    c_im;
  logic signed [QW-1:0]    x;
  logic signed [QW-1:0]    y;
  logic signed [EW-1:0]    xx;
  logic signed [EW-1:0]    yy;
  logic [CNTW-1:0]         blue;

  logic                    mul_start;
  logic [MW-1:0]           mul_a;
  logic [MW-1:0]           mul_b;
  logic                    mul_done;
  logic [MUL_PW-1:0]       mul_product;

  logic                    accept;
  logic                    out_free;
  logic [PW-1:0]           col_m;
  logic [PW-1:0]           row_m;
  logic signed [NW-1:0]    n_re_next;
  logic signed [NW-1:0]    n_im_next;
  logic signed [EW-1:0]    prod_q;
  logic signed [EW-1:0]    xy;
  logic signed [QW-1:0]    x_next;
  logic signed [QW-1:0]    y_next;
  logic                    escape;
  logic [CNTW-1:0]         blue_diff;
  logic [31:0]             blue_scaled;

  assign cfg_ready   = !rst;
  assign pixel_stall = rst || (state != S_IDLE);
  assign accept      = pixel_valid && !pixel_stall;
  assign out_free    = !result_valid || !result_stall;

  assign col_m     = pixel.pixel_column & COORD_MASK;
  assign row_m     = pixel.pixel_row & COORD_MASK;
  assign n_re_next = (NW'(col_m) << 1) - NW'(image_width) + (NW'(position_offset) << 1);
  assign n_im_next = (NW'(row_m) << 1) - NW'(image_height) + (NW'(position_offset) << 1);

  // Product magnitude scaled back to Q10.FRAC_BITS, truncated toward zero.
  assign prod_q = EW'(mul_product >> FRAC_BITS);
  assign xy     = (x[QW-1] ^ y[QW-1]) ? -prod_q : prod_q;
  assign x_next = sat_ext(xx - yy + EW'(c_re));
  assign y_next = sat_ext((xy <<< 1) + EW'(c_im));
  assign escape = (xx + prod_q) > ESC_LIMIT;

  // (cap - count) * 65535 as a shift and subtract
  assign blue_diff   = iteration_cap - count;
  assign blue_scaled = {blue_diff, 16'b0} - {16'b0, blue_diff};

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      S_MAP_RE: begin
        mul_start = !issued;
        mul_a     = MW'(abs_n(n_re));
        mul_b     = MW'(pixel_step);
      end
      S_MAP_IM: begin
        mul_start = !issued;
        mul_a     = MW'(abs_n(n_im));
        mul_b     = MW'(pixel_step);
      end
      S_SQX: begin
        mul_start = !issued;
        mul_a     = MW'(abs_q(x));
        mul_b     = MW'(abs_q(x));
      end
      S_SQY: begin
        mul_start = !issued;
        mul_a     = MW'(abs_q(y));
        mul_b     = MW'(abs_q(y));
      end
      S_XY: begin
        mul_start = !issued;
        mul_a     = MW'(abs_q(x));
        mul_b     = MW'(abs_q(y));
      end
      S_BLUE: begin
        mul_start = !issued;
        mul_a     = MW'(blue_scaled);
        mul_b     = MW'(mbet_pkg::RECIP_10);
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  mbet_mul #(
    .A_WIDTH (MW),
    .B_WIDTH (MW)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_product)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= mbet_pkg::RESET_IMAGE_WIDTH;
      image_height    <= mbet_pkg::RESET_IMAGE_HEIGHT;
      position_offset <= mbet_pkg::RESET_POSITION_OFFSET;
      pixel_step      <= mbet_pkg::RESET_PIXEL_STEP;
      iteration_cap   <= mbet_pkg::RESET_ITERATION_CAP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mbet_pkg::REG_IMAGE_WIDTH:     image_width     <= cfg_data[mbet_pkg::SPAN_WIDTH-1:0];
        mbet_pkg::REG_IMAGE_HEIGHT:    image_height    <= cfg_data[mbet_pkg::SPAN_WIDTH-1:0];
        mbet_pkg::REG_POSITION_OFFSET: begin
          position_offset <= $signed(cfg_data[mbet_pkg::OFFSET_WIDTH-1:0]);
        end
        mbet_pkg::REG_PIXEL_STEP:      pixel_step      <= cfg_data[mbet_pkg::STEP_WIDTH-1:0];
        mbet_pkg::REG_ITERATION_CAP:   iteration_cap   <= cfg_data[CNTW-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      issued       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // drop the output valid after its transfer unless a new result lands
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      if (mul_start) begin
        issued <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            n_re  <= n_re_next;
            n_im  <= n_im_next;
            state <= S_MAP_RE;
          end
        end
        S_MAP_RE: begin
          if (mul_done) begin
            c_re   <= sat_mag(MUL_PW'(mul_product >> 1), n_re[NW-1]);
            issued <= 1'b0;
            state  <= S_MAP_IM;
          end
        end
        S_MAP_IM: begin
          if (mul_done) begin
            c_im   <= sat_mag(MUL_PW'(mul_product >> 1), n_im[NW-1]);
            x      <= '0;
            y      <= '0;
            count  <= '0;
            issued <= 1'b0;
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= (count < iteration_cap) ? S_SQX : S_BLUE;
        end
        S_SQX: begin
          if (mul_done) begin
            xx     <= prod_q;
            issued <= 1'b0;
            state  <= S_SQY;
          end
        end
        S_SQY: begin
          if (mul_done) begin
            yy     <= prod_q;
            issued <= 1'b0;
            state  <= escape ? S_BLUE : S_XY;
          end
        end
        S_XY: begin
          if (mul_done) begin
            x      <= x_next;
            y      <= y_next;
            count  <= count + CNTW'(1);
            issued <= 1'b0;
            state  <= S_CHECK;
          end
        end
        S_BLUE: begin
          if (mul_done) begin
            blue   <= CNTW'(mul_product >> mbet_pkg::RECIP_SHIFT);
            issued <= 1'b0;
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            result.escaped         <= (count < iteration_cap);
            result.iteration_count <= count;
            result.blue_level      <= blue;
            result_valid           <= 1'b1;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state  <= S_IDLE;
          issued <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ src/mbet_mul.sv @@
// Multi-cycle unsigned multiplier, one digit of the second operand per cycle.
`timescale 1ns / 1ps

module mbet_mul #(
  parameter int A_WIDTH = 32,
  parameter int B_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [A_WIDTH-1:0]   a,
  input  logic [B_WIDTH-1:0]   b,
  output logic                 done,
  output logic [A_WIDTH + ((B_WIDTH + mbet_pkg::MUL_DIGIT - 1) / mbet_pkg::MUL_DIGIT)
               * mbet_pkg::MUL_DIGIT - 1:0] product
);

  localparam int DIG    = mbet_pkg::MUL_DIGIT;
  localparam int DIGITS = (B_WIDTH + DIG - 1) / DIG;
  localparam int BP     = DIGITS * DIG;
  localparam int PW     = A_WIDTH + BP;
  localparam int CW     = $clog2(DIGITS + 1);

  logic [A_WIDTH-1:0]     a_reg;
  logic [BP-1:0]          b_reg;
  logic [PW-1:0]          acc;
  logic [CW-1:0]          cnt;
  logic                   busy;
  logic [A_WIDTH+DIG-1:0] partial;

  assign partial = a_reg * b_reg[BP-1 -: DIG];
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIGITS);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Horner form: most significant digit first, shift the sum left each step.
  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      b_reg <= BP'(b);
      acc   <= '0;
    end else if (busy) begin
      acc   <= (acc << DIG) + PW'(partial);
      b_reg <= b_reg << DIG;
    end
  end

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the Mandelbrot escape-time block: directed and random pixels and register sets
`timescale 1ns / 1ps

module tb_top;

  localparam int FRAC_BITS   = 28;
  localparam int COORD_WIDTH = 12;

  typedef longint unsigned u64_t;

  localparam u64_t SAT_MAG   = u64_t'(1) << (FRAC_BITS + 3);
  localparam longint ESCAPE_Q = longint'(mbet_pkg::ESCAPE_LIMIT) <<< FRAC_BITS;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              pixel_valid  = 1'b0;
  logic              pixel_stall;
  mbet_pkg::pixel_t  pixel        = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  mbet_pkg::result_t result;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [mbet_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [mbet_pkg::CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

  // Shadow copy of the block's registers
  int unsigned cfg_width  = mbet_pkg::RESET_IMAGE_WIDTH;
  int unsigned cfg_height = mbet_pkg::RESET_IMAGE_HEIGHT;
  longint      cfg_offset = mbet_pkg::RESET_POSITION_OFFSET;
  u64_t        cfg_step   = mbet_pkg::RESET_PIXEL_STEP;
  int unsigned cfg_cap    = mbet_pkg::RESET_ITERATION_CAP;

  mbet_pkg::pixel_t  pixels_to_send[$];
  mbet_pkg::result_t predicted_escapes[$];

  int burst_left = 0;
  int gap_left   = 0;
  int stall_left = 0;
  int free_left  = 0;

  int pixels_sent      = 0;
  int results_checked  = 0;
  int mismatches       = 0;
  int escaped_seen     = 0;
  int capped_seen      = 0;
  int deepest_count    = 0;
  int settings_written = 0;

  mandelbrot_escape_time #(
    .FRAC_BITS  (FRAC_BITS),
    .COORD_WIDTH(COORD_WIDTH)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic u64_t magnitude(longint v);
    return (v < 0) ? u64_t'(-v) : u64_t'(v);
  endfunction

  // Signed value from magnitude and sign, clamped to [-8, 8)
  function automatic longint clamp_q(u64_t mag, bit neg);
    if (neg)
      return (mag >= SAT_MAG) ? -longint'(SAT_MAG) : -longint'(mag);
    return (mag > SAT_MAG - 1) ? longint'(SAT_MAG - 1) : longint'(mag);
  endfunction

  function automatic longint saturate(longint v);
    return clamp_q(magnitude(v), v < 0);
  endfunction

  // Product on magnitudes, truncated toward zero, then signed
  function automatic longint q_mul(longint a, longint b);
    u64_t m;
    m = (magnitude(a) * magnitude(b)) >> FRAC_BITS;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint map_point(int unsigned pos, int unsigned span);
    longint n;
    u64_t   m;
    n = 2 * longint'(pos) - longint'(span) + 2 * cfg_offset;
    m = (magnitude(n) * cfg_step) >> 1;
    return clamp_q(m, n < 0);
  endfunction

  function automatic mbet_pkg::result_t escape_time(mbet_pkg::pixel_t px);
    longint            c_re, c_im, x, y, xx, yy, x_next;
    int unsigned       count;
    bit                out_of_bounds;
    mbet_pkg::result_t r;
    c_re = map_point(px.pixel_column, cfg_width);
    c_im = map_point(px.pixel_row, cfg_height);
    x = 0;
    y = 0;
    count = 0;
    out_of_bounds = 1'b0;
    while (count < cfg_cap && !out_of_bounds) begin
      xx = q_mul(x, x);
      yy = q_mul(y, y);
      if (xx + yy > ESCAPE_Q) begin
        out_of_bounds = 1'b1;
      end else begin
        x_next = saturate(xx - yy + c_re);
        y = saturate(2 * q_mul(x, y) + c_im);
        x = x_next;
        count++;
      end
    end
    r.escaped         = (count < cfg_cap);
    r.iteration_count = mbet_pkg::COUNT_WIDTH'(count);
    r.blue_level      = mbet_pkg::COUNT_WIDTH'((u64_t'(cfg_cap - count) * 65535) / 10);
    return r;
  endfunction

  function automatic mbet_pkg::pixel_t random_pixel();
    mbet_pkg::pixel_t p;
    if ($urandom_range(0, 3) != 0) begin
      p.pixel_column = mbet_pkg::PIXEL_WIDTH'($urandom_range(0, cfg_width - 1));
      p.pixel_row    = mbet_pkg::PIXEL_WIDTH'($urandom_range(0, cfg_height - 1));
    end else begin
      p.pixel_column = mbet_pkg::PIXEL_WIDTH'($urandom);
      p.pixel_row    = mbet_pkg::PIXEL_WIDTH'($urandom);
    end
    return p;
  endfunction

  task automatic queue_pixel(int unsigned col, int unsigned row);
    mbet_pkg::pixel_t p;
    p.pixel_column = mbet_pkg::PIXEL_WIDTH'(col);
    p.pixel_row    = mbet_pkg::PIXEL_WIDTH'(row);
    pixels_to_send.push_back(p);
  endtask

  task automatic send_random(int n);
    repeat (n) pixels_to_send.push_back(random_pixel());
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pixels_to_send.size() != 0 || pixel_valid || predicted_escapes.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write all five registers back to back; valid stays high across transfers
  task automatic write_config(int unsigned w, int unsigned h, int off,
                              logic [31:0] step, int unsigned cap);
    logic [mbet_pkg::CFG_INDEX_WIDTH-1:0] idx[5];
    logic [mbet_pkg::CFG_DATA_WIDTH-1:0]  val[5];
    idx = '{mbet_pkg::REG_IMAGE_WIDTH, mbet_pkg::REG_IMAGE_HEIGHT,
            mbet_pkg::REG_POSITION_OFFSET, mbet_pkg::REG_PIXEL_STEP,
            mbet_pkg::REG_ITERATION_CAP};
    val = '{mbet_pkg::CFG_DATA_WIDTH'(w), mbet_pkg::CFG_DATA_WIDTH'(h),
            mbet_pkg::CFG_DATA_WIDTH'(off), step, mbet_pkg::CFG_DATA_WIDTH'(cap)};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk);
      while (!cfg_ready);
      case (idx[i])
        mbet_pkg::REG_IMAGE_WIDTH:
          cfg_width  = val[i][mbet_pkg::SPAN_WIDTH-1:0];
        mbet_pkg::REG_IMAGE_HEIGHT:
          cfg_height = val[i][mbet_pkg::SPAN_WIDTH-1:0];
        mbet_pkg::REG_POSITION_OFFSET:
          cfg_offset = longint'($signed(val[i][mbet_pkg::OFFSET_WIDTH-1:0]));
        mbet_pkg::REG_PIXEL_STEP:
          cfg_step   = u64_t'(val[i]);
        mbet_pkg::REG_ITERATION_CAP:
          cfg_cap    = val[i][mbet_pkg::COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    settings_written++;
  endtask

  // Pixel driver: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      if (pixel_valid && !pixel_stall) begin
        predicted_escapes.push_back(escape_time(pixel));
        pixels_sent++;
      end
      if (!pixel_valid || !pixel_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          pixel_valid <= 1'b0;
        end else if (pixels_to_send.size() > 0) begin
          pixel       <= pixels_to_send.pop_front();
          pixel_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
          end
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: stall in runs, with free stretches in between
  always @(posedge clk) begin
    mbet_pkg::result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (predicted_escapes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: escaped %0b count %0d blue %0d",
                     result.escaped, result.iteration_count, result.blue_level);
        end else begin
          want = predicted_escapes.pop_front();
          if (result.escaped !== want.escaped ||
              result.iteration_count !== want.iteration_count ||
              result.blue_level !== want.blue_level) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: escaped %0b/%0b count %0d/%0d blue %0d/%0d (exp/got)",
                       results_checked, want.escaped, result.escaped,
                       want.iteration_count, result.iteration_count,
                       want.blue_level, result.blue_level);
          end
          if (want.escaped) escaped_seen++;
          else capped_seen++;
          if (int'(want.iteration_count) > deepest_count)
            deepest_count = want.iteration_count;
          results_checked++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if (free_left > 0) begin
        free_left--;
        result_stall <= 1'b0;
      end else begin
        free_left  = $urandom_range(0, 80);
        stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned span_w, span_h;
    int          off;
    logic [31:0] step;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: corners, origin, bulbs and boundary points
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(0, 4095);
    queue_pixel(4095, 0);
    queue_pixel(250, 250);
    queue_pixel(125, 250);
    queue_pixel(100, 250);
    queue_pixel(50, 250);
    queue_pixel(350, 250);
    queue_pixel(250, 375);
    queue_pixel(250, 0);
    queue_pixel(12'hAAA, 12'h555);
    queue_pixel(12'h555, 12'hAAA);
    queue_pixel(200, 300);
    queue_pixel(310, 260);
    send_random(75);
    wait_idle();
    send_random(75);
    wait_idle();

    // Narrowest frame, minimum cap
    write_config(1, 4096, 0, 32'h0010_0000, 1);
    send_random(50);
    wait_idle();

    // Most negative offset, largest step and cap: c clamps low, escapes at once
    write_config(4096, 1, -65536, 32'hFFFF_FFFF, 65535);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    send_random(30);
    wait_idle();

    // Most positive offset: c clamps high
    write_config($urandom_range(1, 4096), $urandom_range(1, 4096), 65535, 32'hFFFF_FFFF, 65535);
    send_random(30);
    wait_idle();

    // Zero step: every point sits at the origin and runs to the cap
    write_config(500, 500, 0, 32'h0, 7);
    send_random(40);
    wait_idle();

    // Tiny frame with coarse step
    write_config(2, 3, 1, 32'h0800_0000, 60);
    send_random(40);
    wait_idle();

    for (int k = 0; k < 8; k++) begin
      span_w = $urandom_range(1, 4096);
      span_h = $urandom_range(1, 4096);
      // Scale so the frame spans roughly four units, with some zoom jitter
      step = 32'h4000_0000 / ((span_w > span_h) ? span_w : span_h);
      step = step + step / 100 * $urandom_range(0, 50);
      if (k == 6) step = $urandom;
      off = (k == 3) ? int'($urandom_range(0, 131071)) - 65536
                     : int'($urandom_range(0, 64)) - 32;
      write_config(span_w, span_h, off, step, $urandom_range(1, 40));
      send_random(80);
      wait_idle();
      send_random(85);
      wait_idle();
    end

    repeat (40) @(posedge clk);
    $display("%0d pixels sent, %0d results checked under %0d register settings",
             pixels_sent, results_checked, settings_written + 1);
    $display("%0d escaped, %0d held to the cap, deepest count %0d",
             escaped_seen, capped_seen, deepest_count);
    if (mismatches == 0 && predicted_escapes.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout after %0d results", results_checked);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
